// ===== src/prmf_pkg.sv =====
`timescale 1ns / 1ps

package prmf_pkg;

	localparam int VTX_FIELD_W = 6;
	localparam int CFG_W       = 7;
	localparam int HGT_W       = 20;
	localparam int STEP_W      = 19;
	localparam int FLOW_OUT_W  = 24;

	localparam logic [CFG_W-1:0]      VCOUNT_RST = 7'd64;
	localparam logic [STEP_W-1:0]     STEP_LIMIT = 19'd262144;
	localparam logic [FLOW_OUT_W-1:0] FLOW_MAX   = 24'hFFFFFF;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_PF_RD,
		ST_PF_CHK,
		ST_PF_VX,
		ST_STEP,
		ST_FIND_RD,
		ST_FIND_CHK,
		ST_SCAN_RD,
		ST_SCAN_EDGE,
		ST_SCAN_VX,
		ST_PUSH_SRC,
		ST_PUSH_DST,
		ST_REV_RD,
		ST_REV_CHK,
		ST_RELABEL,
		ST_RES_RD,
		ST_RES_WAIT
	} state_t;

endpackage

// ===== src/prmf_ram.sv =====
`timescale 1ns / 1ps

module prmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/push_relabel_max_flow_core.sv =====
`timescale 1ns / 1ps

// Push-relabel max flow engine. Edges (from_vertex, to_vertex, edge_capacity) are taken one
// word per cycle while idle and appended to the edge RAM; the word with last_edge set starts
// the solve on vertex 0 (source) to vertex_count-1 (sink). The solve runs from the edge RAM
// and a vertex RAM holding height and excess, both with one read and one write port and a
// registered read, so its time is data dependent: it clears the vertex RAM, runs the preflow
// over the stored edges, then per push/relabel step scans the inner vertices for the active
// vertex and the stored edges, and for a push does one more edge scan for the reverse edge.
// Solving stops after 262144 steps. While solving, in_stall is high; the result word sits in
// an output register until taken.

module push_relabel_max_flow_core #(
	parameter int MAX_VERTICES  = 64,
	parameter int MAX_EDGES     = 256,
	parameter int CAPACITY_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [prmf_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [prmf_pkg::VTX_FIELD_W-1:0]    from_vertex,
	input  logic [prmf_pkg::VTX_FIELD_W-1:0]    to_vertex,
	input  logic [15:0]                         edge_capacity,
	input  logic                                last_edge,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [prmf_pkg::FLOW_OUT_W-1:0]     max_flow,
	output logic                                store_overflow
);

	localparam int VFW    = prmf_pkg::VTX_FIELD_W;
	localparam int HW     = prmf_pkg::HGT_W;
	localparam int VW     = $clog2(MAX_VERTICES);
	localparam int NVW    = $clog2(MAX_VERTICES + 1);
	localparam int CW     = (NVW > VFW) ? NVW : VFW;
	localparam int EW     = $clog2(MAX_EDGES);
	localparam int CNTW   = $clog2(MAX_EDGES + 1);
	localparam int EXC_W  = CAPACITY_BITS + CNTW;
	localparam int FLOW_W = EXC_W + 21;
	localparam int EDGE_W = FLOW_W + EXC_W + 2 * VFW;
	localparam int VTX_W  = HW + EXC_W;
	localparam logic [EXC_W-1:0] CAP_MASK = EXC_W'((64'd1 << CAPACITY_BITS) - 64'd1);

	typedef struct packed {
		logic signed [FLOW_W-1:0] flow;
		logic [EXC_W-1:0]         cap;
		logic [VFW-1:0]           tail;
		logic [VFW-1:0]           head;
	} edge_t;

	typedef struct packed {
		logic [HW-1:0]    h;
		logic [EXC_W-1:0] e;
	} vtx_t;

	function automatic logic [VW-1:0] vaddr(input logic [VFW-1:0] ep);
		logic [VW+VFW-1:0] t;
		t = {{VW{1'b0}}, ep};
		return t[VW-1:0];
	endfunction

	function automatic logic signed [FLOW_W-1:0] to_flow(input logic [EXC_W-1:0] c);
		return $signed({{(FLOW_W-EXC_W){1'b0}}, c});
	endfunction

	prmf_pkg::state_t state_q, state_d;

	logic [prmf_pkg::CFG_W-1:0]  cfg_q;
	logic [CNTW-1:0]             count_q;
	logic                        ovf_q;
	logic [NVW-1:0]              nv_q;
	logic [CNTW-1:0]             idx_q;
	logic [VW-1:0]               vidx_q;
	logic [VW-1:0]               u_q;
	logic [HW-1:0]               hu_q;
	logic [EXC_W-1:0]            eu_q;
	logic [HW-1:0]               hv_q;
	logic [EXC_W-1:0]            ev_q;
	logic [HW-1:0]               min_q;
	logic                        any_q;
	logic [EXC_W-1:0]            amt_q;
	logic [prmf_pkg::STEP_W-1:0] steps_q;
	edge_t                       ed_q;
	logic                        out_valid_q;
	logic [prmf_pkg::FLOW_OUT_W-1:0] max_flow_q;
	logic                        store_overflow_q;

	logic              e_we, v_we;
	logic [EW-1:0]     e_waddr, e_raddr;
	logic [VW-1:0]     v_waddr, v_raddr;
	logic [EDGE_W-1:0] e_wdata, e_rdata;
	logic [VTX_W-1:0]  v_wdata, v_rdata;

	edge_t er, ew;
	vtx_t  vr, vw;

	logic in_acc, out_free, full, count_end, er_usable;
	logic pf_hit, scan_hit, push_ok, rev_hit, step_end;
	logic [NVW-1:0] nv_m1, nv_m2, nv_clamp, vidx_n;
	logic [NVW+6:0] cfg_x;
	logic [EXC_W+15:0] cap_x;
	logic [EXC_W-1:0] cap_in, amt_c;
	logic signed [FLOW_W:0] room;
	logic [EXC_W+prmf_pkg::FLOW_OUT_W-1:0] sink_x;

	prmf_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES), .AW(EW)) u_edge_ram (
		.clk  (clk),
		.we   (e_we),
		.waddr(e_waddr),
		.wdata(e_wdata),
		.raddr(e_raddr),
		.rdata(e_rdata)
	);

	prmf_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES), .AW(VW)) u_vtx_ram (
		.clk  (clk),
		.we   (v_we),
		.waddr(v_waddr),
		.wdata(v_wdata),
		.raddr(v_raddr),
		.rdata(v_rdata)
	);

	always_comb begin
		er        = edge_t'(e_rdata);
		vr        = vtx_t'(v_rdata);
		in_stall  = (state_q != prmf_pkg::ST_IDLE);
		in_acc    = in_valid && !in_stall;
		out_free  = !out_valid_q || !out_stall;
		full      = (count_q >= CNTW'(MAX_EDGES));
		count_end = (idx_q == count_q);
		er_usable = (CW'(er.tail) < CW'(nv_q)) && (CW'(er.head) < CW'(nv_q));
		pf_hit    = (er.tail == '0) && er_usable;
		scan_hit  = (CW'(er.tail) == CW'(u_q)) && er_usable && (er.flow != to_flow(er.cap));
		push_ok   = (hu_q > vr.h);
		rev_hit   = (er.tail == ed_q.head) && (er.head == ed_q.tail);
		step_end  = (steps_q == prmf_pkg::STEP_LIMIT) || (nv_q < NVW'(3));
		nv_m1     = nv_q - NVW'(1);
		nv_m2     = nv_q - NVW'(2);
		vidx_n    = NVW'(vidx_q);
		cfg_x     = (NVW+7)'(cfg_q);
		if (cfg_x < (NVW+7)'(2)) begin
			nv_clamp = NVW'(2);
		end else if (cfg_x > (NVW+7)'(MAX_VERTICES)) begin
			nv_clamp = NVW'(MAX_VERTICES);
		end else begin
			nv_clamp = cfg_x[NVW-1:0];
		end
		cap_x  = {{EXC_W{1'b0}}, edge_capacity};
		cap_in = cap_x[EXC_W-1:0] & CAP_MASK;
		room   = {1'b0, to_flow(ed_q.cap)} - {ed_q.flow[FLOW_W-1], ed_q.flow};
		if (room < $signed({{(FLOW_W+1-EXC_W){1'b0}}, eu_q})) begin
			amt_c = room[EXC_W-1:0];
		end else begin
			amt_c = eu_q;
		end
		sink_x = {{prmf_pkg::FLOW_OUT_W{1'b0}}, vr.e};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			prmf_pkg::ST_IDLE: begin
				if (in_acc && last_edge) state_d = prmf_pkg::ST_CLR;
			end
			prmf_pkg::ST_CLR: begin
				if (vidx_n == nv_m1) state_d = prmf_pkg::ST_PF_RD;
			end
			prmf_pkg::ST_PF_RD: begin
				state_d = count_end ? prmf_pkg::ST_STEP : prmf_pkg::ST_PF_CHK;
			end
			prmf_pkg::ST_PF_CHK: begin
				state_d = pf_hit ? prmf_pkg::ST_PF_VX : prmf_pkg::ST_PF_RD;
			end
			prmf_pkg::ST_PF_VX: state_d = prmf_pkg::ST_PF_RD;
			prmf_pkg::ST_STEP: begin
				state_d = step_end ? prmf_pkg::ST_RES_RD : prmf_pkg::ST_FIND_RD;
			end
			prmf_pkg::ST_FIND_RD: state_d = prmf_pkg::ST_FIND_CHK;
			prmf_pkg::ST_FIND_CHK: begin
				if (vr.e != '0) begin
					state_d = prmf_pkg::ST_SCAN_RD;
				end else if (vidx_n == nv_m2) begin
					state_d = prmf_pkg::ST_RES_RD;
				end else begin
					state_d = prmf_pkg::ST_FIND_RD;
				end
			end
			prmf_pkg::ST_SCAN_RD: begin
				if (!count_end) begin
					state_d = prmf_pkg::ST_SCAN_EDGE;
				end else if (any_q) begin
					state_d = prmf_pkg::ST_RELABEL;
				end else begin
					state_d = prmf_pkg::ST_STEP;
				end
			end
			prmf_pkg::ST_SCAN_EDGE: begin
				state_d = scan_hit ? prmf_pkg::ST_SCAN_VX : prmf_pkg::ST_SCAN_RD;
			end
			prmf_pkg::ST_SCAN_VX: begin
				state_d = push_ok ? prmf_pkg::ST_PUSH_SRC : prmf_pkg::ST_SCAN_RD;
			end
			prmf_pkg::ST_PUSH_SRC: state_d = prmf_pkg::ST_PUSH_DST;
			prmf_pkg::ST_PUSH_DST: state_d = prmf_pkg::ST_REV_RD;
			prmf_pkg::ST_REV_RD: begin
				state_d = count_end ? prmf_pkg::ST_STEP : prmf_pkg::ST_REV_CHK;
			end
			prmf_pkg::ST_REV_CHK: begin
				state_d = rev_hit ? prmf_pkg::ST_STEP : prmf_pkg::ST_REV_RD;
			end
			prmf_pkg::ST_RELABEL: state_d = prmf_pkg::ST_STEP;
			prmf_pkg::ST_RES_RD: state_d = prmf_pkg::ST_RES_WAIT;
			prmf_pkg::ST_RES_WAIT: begin
				if (out_free) state_d = prmf_pkg::ST_IDLE;
			end
			default: state_d = prmf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		e_we    = 1'b0;
		e_waddr = count_q[EW-1:0];
		e_raddr = idx_q[EW-1:0];
		ew      = er;
		v_we    = 1'b0;
		v_waddr = vidx_q;
		v_raddr = vidx_q;
		vw      = vr;
		case (state_q)
			prmf_pkg::ST_IDLE: begin
				e_we = in_acc && !full;
				ew   = '{flow: '0, cap: cap_in, tail: from_vertex, head: to_vertex};
			end
			prmf_pkg::ST_CLR: begin
				v_we = 1'b1;
				vw   = '{h: (vidx_q == '0) ? HW'(nv_q) : '0, e: '0};
			end
			prmf_pkg::ST_PF_CHK: begin
				e_we    = pf_hit;
				e_waddr = idx_q[EW-1:0];
				ew.flow = to_flow(er.cap);
				v_raddr = vaddr(er.head);
			end
			prmf_pkg::ST_PF_VX: begin
				e_we    = !full;
				ew      = '{flow: -to_flow(ed_q.cap), cap: '0, tail: ed_q.head, head: '0};
				v_we    = 1'b1;
				v_waddr = vaddr(ed_q.head);
				vw      = '{h: vr.h, e: vr.e + ed_q.cap};
			end
			prmf_pkg::ST_SCAN_EDGE: begin
				v_raddr = vaddr(er.head);
			end
			prmf_pkg::ST_SCAN_VX: begin
				e_we    = push_ok;
				e_waddr = idx_q[EW-1:0];
				ew      = ed_q;
				ew.flow = ed_q.flow + to_flow(amt_c);
			end
			prmf_pkg::ST_PUSH_SRC: begin
				v_we    = 1'b1;
				v_waddr = u_q;
				vw      = '{h: hu_q, e: eu_q - amt_q};
			end
			prmf_pkg::ST_PUSH_DST: begin
				v_we    = 1'b1;
				v_waddr = vaddr(ed_q.head);
				vw      = '{h: hv_q, e: ev_q + amt_q};
			end
			prmf_pkg::ST_REV_RD: begin
				e_we = count_end && !full;
				ew   = '{flow: '0, cap: amt_q, tail: ed_q.head, head: ed_q.tail};
			end
			prmf_pkg::ST_REV_CHK: begin
				e_we    = rev_hit;
				e_waddr = idx_q[EW-1:0];
				ew.flow = er.flow - to_flow(amt_q);
			end
			prmf_pkg::ST_RELABEL: begin
				v_we    = 1'b1;
				v_waddr = u_q;
				vw      = '{h: min_q + HW'(1), e: eu_q};
			end
			prmf_pkg::ST_RES_RD, prmf_pkg::ST_RES_WAIT: begin
				v_raddr = nv_m1[VW-1:0];
			end
			default: begin
			end
		endcase
		e_wdata = EDGE_W'(ew);
		v_wdata = VTX_W'(vw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= prmf_pkg::ST_IDLE;
			cfg_q       <= prmf_pkg::VCOUNT_RST;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cfg_q <= cfg_data;
			if (state_q == prmf_pkg::ST_RES_WAIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				prmf_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (full) ovf_q <= 1'b1;
						else count_q <= count_q + CNTW'(1);
					end
				end
				prmf_pkg::ST_PF_VX: begin
					if (full) ovf_q <= 1'b1;
					else count_q <= count_q + CNTW'(1);
				end
				prmf_pkg::ST_REV_RD: begin
					if (count_end) begin
						if (full) ovf_q <= 1'b1;
						else count_q <= count_q + CNTW'(1);
					end
				end
				prmf_pkg::ST_RES_WAIT: begin
					if (out_free) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			prmf_pkg::ST_IDLE: begin
				nv_q   <= nv_clamp;
				vidx_q <= '0;
			end
			prmf_pkg::ST_CLR: begin
				vidx_q <= vidx_q + VW'(1);
				idx_q  <= '0;
			end
			prmf_pkg::ST_PF_RD: begin
				steps_q <= '0;
			end
			prmf_pkg::ST_PF_CHK: begin
				if (pf_hit) ed_q <= er;
				else idx_q <= idx_q + CNTW'(1);
			end
			prmf_pkg::ST_PF_VX: begin
				idx_q <= idx_q + CNTW'(1);
			end
			prmf_pkg::ST_STEP: begin
				vidx_q <= VW'(1);
			end
			prmf_pkg::ST_FIND_CHK: begin
				if (vr.e != '0) begin
					u_q   <= vidx_q;
					hu_q  <= vr.h;
					eu_q  <= vr.e;
					idx_q <= '0;
					any_q <= 1'b0;
				end else begin
					vidx_q <= vidx_q + VW'(1);
				end
			end
			prmf_pkg::ST_SCAN_RD: begin
				if (count_end && !any_q) steps_q <= steps_q + prmf_pkg::STEP_W'(1);
			end
			prmf_pkg::ST_SCAN_EDGE: begin
				if (scan_hit) ed_q <= er;
				else idx_q <= idx_q + CNTW'(1);
			end
			prmf_pkg::ST_SCAN_VX: begin
				if (push_ok) begin
					amt_q <= amt_c;
					hv_q  <= vr.h;
					ev_q  <= vr.e;
				end else begin
					if (!any_q || vr.h < min_q) min_q <= vr.h;
					any_q <= 1'b1;
					idx_q <= idx_q + CNTW'(1);
				end
			end
			prmf_pkg::ST_PUSH_DST: begin
				idx_q <= '0;
			end
			prmf_pkg::ST_REV_RD: begin
				if (count_end) steps_q <= steps_q + prmf_pkg::STEP_W'(1);
			end
			prmf_pkg::ST_REV_CHK: begin
				if (rev_hit) steps_q <= steps_q + prmf_pkg::STEP_W'(1);
				else idx_q <= idx_q + CNTW'(1);
			end
			prmf_pkg::ST_RELABEL: begin
				steps_q <= steps_q + prmf_pkg::STEP_W'(1);
			end
			prmf_pkg::ST_RES_WAIT: begin
				if (out_free) begin
					if (sink_x > (EXC_W+prmf_pkg::FLOW_OUT_W)'(prmf_pkg::FLOW_MAX)) begin
						max_flow_q <= prmf_pkg::FLOW_MAX;
					end else begin
						max_flow_q <= sink_x[prmf_pkg::FLOW_OUT_W-1:0];
					end
					store_overflow_q <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign max_flow       = max_flow_q;
	assign store_overflow = store_overflow_q;

endmodule
